/* sv/pae_pkg.sv */
package pae_pkg;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 4;
	localparam int COUNT_W = 5;
	localparam int KIND_W  = 2;

	// Request codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Result classes.
	localparam logic [KIND_W-1:0] HIT_OUTSIDE = 2'd0;
	localparam logic [KIND_W-1:0] HIT_EXACT   = 2'd1;
	localparam logic [KIND_W-1:0] HIT_SEGMENT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_COMPARE,
		ST_MULTIPLY,
		ST_ADD,
		ST_FINISH
	} pae_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic start;
		logic rd_scan;
		logic rd_seg;
		logic scan_next;
		logic mul;
		logic set_outside;
		logic set_exact;
		logic set_seg;
		logic push;
	} pae_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic ge;
		logic eq;
		logic last;
		logic sel_zero;
		logic out_free;
	} pae_status_t;

endpackage

/* sv/pae_if.sv */
interface pae_in_if import pae_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [INDEX_W-1:0]       entry_index;
	logic signed [DATA_W-1:0] position;
	logic signed [DATA_W-1:0] point_value;
	logic signed [DATA_W-1:0] segment_slope;
	logic signed [DATA_W-1:0] segment_offset;

	modport source (
		output valid, cmd, entry_index, position, point_value, segment_slope,
			segment_offset,
		input  ready
	);
	modport sink (
		input  valid, cmd, entry_index, position, point_value, segment_slope,
			segment_offset,
		output ready
	);
endinterface

interface pae_out_if import pae_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic [KIND_W-1:0]        hit_kind;
	logic                     saturated;

	modport source (
		output valid, result_value, hit_kind, saturated,
		input  ready
	);
	modport sink (
		input  valid, result_value, hit_kind, saturated,
		output ready
	);
endinterface

/* sv/piecewise_affine_evaluator_top.sv */
// Piecewise affine function evaluator. The block holds a table of up to
// MAX_POINTS breakpoints, each with a position, the function value at that
// position and the slope and offset of the segment to its right, all signed
// fixed point with FRAC_BITS fractional bits. A load request writes one entry
// and gives no result; a load to an entry beyond the table is dropped. An
// evaluate request always gives one result. The table is scanned in index
// order through one registered read port until the first valid breakpoint at
// or above the query position is found. An exact match returns the stored
// point value, a query before the first breakpoint or past the last returns
// zero as outside, and otherwise the preceding segment is applied: one
// 32 by 32 multiply, an arithmetic right shift that rounds towards minus
// infinity, then an add that saturates to the 32-bit range and raises the
// saturated flag. A new request is taken once the previous one has placed
// its result in the output register, so a result may wait there while the
// next request is already being worked on. The breakpoint count is to be
// written through cfg_we and cfg_wdata only while the block is idle; the
// block itself does not enforce this. A count above MAX_POINTS is taken as
// MAX_POINTS and a count of zero makes every query fall outside.
module piecewise_affine_evaluator_top import pae_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	pae_in_if.sink             req,
	pae_out_if.source          rsp
);

	pae_cmd_t    cmd;
	pae_status_t status;
	logic        in_ready;

	// The controller sequences the scan, the multiply and the final add.
	pae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.cmd),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	// The datapath holds the table, the query registers and the output register.
	pae_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.entry_index    (req.entry_index),
		.position       (req.position),
		.point_value    (req.point_value),
		.segment_slope  (req.segment_slope),
		.segment_offset (req.segment_offset),
		.out_ready      (rsp.ready),
		.out_valid      (rsp.valid),
		.result_value   (rsp.result_value),
		.hit_kind       (rsp.hit_kind),
		.saturated      (rsp.saturated),
		.cmd            (cmd),
		.status         (status)
	);

endmodule

/* sv/pae_ctrl.sv */
module pae_ctrl import pae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_cmd,
	output logic        in_ready,
	input  pae_status_t status,
	output pae_cmd_t    cmd
);

	pae_state_t state_q;
	pae_state_t state_d;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == CMD_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd_scan = 1'b1;
				state_d     = ST_COMPARE;
			end
			ST_COMPARE: begin
				priority if (status.count_zero) begin
					cmd.set_outside = 1'b1;
					state_d         = ST_FINISH;
				end else if (status.ge && status.eq) begin
					cmd.set_exact = 1'b1;
					state_d       = ST_FINISH;
				end else if (status.ge && status.sel_zero) begin
					cmd.set_outside = 1'b1;
					state_d         = ST_FINISH;
				end else if (status.ge) begin
					cmd.rd_seg = 1'b1;
					state_d    = ST_MULTIPLY;
				end else if (status.last) begin
					cmd.set_outside = 1'b1;
					state_d         = ST_FINISH;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = ST_READ;
				end
			end
			ST_MULTIPLY: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.set_seg = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/pae_datapath.sv */
module pae_datapath import pae_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [COUNT_W-1:0]       cfg_wdata,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic signed [DATA_W-1:0] position,
	input  logic signed [DATA_W-1:0] point_value,
	input  logic signed [DATA_W-1:0] segment_slope,
	input  logic signed [DATA_W-1:0] segment_offset,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] result_value,
	output logic [KIND_W-1:0]        hit_kind,
	output logic                     saturated,
	input  pae_cmd_t                 cmd,
	output pae_status_t              status
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W = PROD_W + 1;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sh0000_0000_8000_0000);

	logic signed [DATA_W-1:0] pos_mem   [MAX_POINTS];
	logic signed [DATA_W-1:0] val_mem   [MAX_POINTS];
	logic signed [DATA_W-1:0] slope_mem [MAX_POINTS];
	logic signed [DATA_W-1:0] off_mem   [MAX_POINTS];

	logic [COUNT_W-1:0]       point_count_q;
	logic                     e0_written_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         scan_q;
	logic signed [DATA_W-1:0] pos_q;
	logic signed [DATA_W-1:0] rd_pos_q;
	logic signed [DATA_W-1:0] rd_val_q;
	logic signed [DATA_W-1:0] rd_slope_q;
	logic signed [DATA_W-1:0] rd_off_q;
	logic                     rd_blank_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] res_val_q;
	logic [KIND_W-1:0]        res_kind_q;
	logic                     res_sat_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_val_q;
	logic [KIND_W-1:0]        out_kind_q;
	logic                     out_sat_q;

	logic                     load_ok;
	logic [IDX_W-1:0]         wr_addr;
	logic [IDX_W-1:0]         rd_addr;
	logic                     rd_en;
	logic [CNT_W-1:0]         count_clip;
	logic signed [DATA_W-1:0] eff_pos;
	logic signed [DATA_W-1:0] eff_val;
	logic signed [PROD_W-1:0] shifted;
	logic signed [SUM_W-1:0]  sum;

	assign load_ok = (int'(entry_index) < MAX_POINTS);
	assign wr_addr = IDX_W'(entry_index);
	assign rd_en   = cmd.rd_scan || cmd.rd_seg;
	assign rd_addr = cmd.rd_seg ? (scan_q - IDX_W'(1)) : scan_q;

	always_comb begin
		if (int'(point_count_q) > MAX_POINTS) begin
			count_clip = CNT_W'(MAX_POINTS);
		end else begin
			count_clip = CNT_W'(point_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= COUNT_W'(1);
			e0_written_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				point_count_q <= cfg_wdata;
			end
			if (cmd.load && (entry_index == '0)) begin
				e0_written_q <= 1'b1;
			end
		end
	end

	// Table storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			pos_mem[wr_addr]   <= position;
			val_mem[wr_addr]   <= point_value;
			slope_mem[wr_addr] <= segment_slope;
			off_mem[wr_addr]   <= segment_offset;
		end
		if (rd_en) begin
			rd_pos_q   <= pos_mem[rd_addr];
			rd_val_q   <= val_mem[rd_addr];
			rd_slope_q <= slope_mem[rd_addr];
			rd_off_q   <= off_mem[rd_addr];
		end
	end

	// The position and value of entry zero read as zero until it has been loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_blank_q <= 1'b0;
		end else if (rd_en) begin
			rd_blank_q <= (rd_addr == '0) && !e0_written_q;
		end
	end

	assign eff_pos = rd_blank_q ? '0 : rd_pos_q;
	assign eff_val = rd_blank_q ? '0 : rd_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
		end else if (cmd.start) begin
			count_q <= count_clip;
			scan_q  <= '0;
		end else if (cmd.scan_next) begin
			scan_q <= scan_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q <= position;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(rd_slope_q) * PROD_W'(pos_q);
		end
	end

	assign shifted = prod_q >>> FRAC_BITS;
	assign sum     = {shifted[PROD_W-1], shifted}
		+ {{(SUM_W - DATA_W){rd_off_q[DATA_W-1]}}, rd_off_q};

	always_ff @(posedge clk) begin
		if (cmd.set_outside) begin
			res_val_q  <= '0;
			res_kind_q <= HIT_OUTSIDE;
			res_sat_q  <= 1'b0;
		end else if (cmd.set_exact) begin
			res_val_q  <= eff_val;
			res_kind_q <= HIT_EXACT;
			res_sat_q  <= 1'b0;
		end else if (cmd.set_seg) begin
			res_kind_q <= HIT_SEGMENT;
			if (sum > SUM_MAX) begin
				res_val_q <= DATA_W'(SUM_MAX);
				res_sat_q <= 1'b1;
			end else if (sum < SUM_MIN) begin
				res_val_q <= DATA_W'(SUM_MIN);
				res_sat_q <= 1'b1;
			end else begin
				res_val_q <= DATA_W'(sum);
				res_sat_q <= 1'b0;
			end
		end
	end

	// Output register: holds the finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_val_q  <= res_val_q;
			out_kind_q <= res_kind_q;
			out_sat_q  <= res_sat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign hit_kind     = out_kind_q;
	assign saturated    = out_sat_q;

	assign status.count_zero = (count_q == '0);
	assign status.ge         = (eff_pos >= pos_q);
	assign status.eq         = (eff_pos == pos_q);
	assign status.last       = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);
	assign status.sel_zero   = (scan_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import pae_pkg::*;

	localparam int MAX_POINTS      = 16;
	localparam int FRAC_BITS       = 16;
	// The longest evaluate request examines every breakpoint.
	// The settling pause before a register write and at the end covers it.
	localparam int SETTLE_CYCLES   = 40;
	// Longest stretch with no handshake on any channel that a correct block
	// can show: one full scan, the longest receiver stall, the longest sender
	// gap and a settling pause. The limit is that figure taken many times over.
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 180;

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [KIND_W-1:0]        kind;
		logic                     saturated;
	} evaluation_t;

	typedef struct {
		logic                     cmd;
		logic [INDEX_W-1:0]       entry_index;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] point_value;
		logic signed [DATA_W-1:0] segment_slope;
		logic signed [DATA_W-1:0] segment_offset;
	} request_t;

	// Kinds of line in the directed table. A line with a typed answer carries
	// the result that is expected; a plain query line is left to the
	// predictor. A count line rewrites the breakpoint count once idle.
	typedef enum int {ROW_LOAD, ROW_QUERY, ROW_EXPECT, ROW_COUNT} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		int                       arg;
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] point_value;
		logic signed [DATA_W-1:0] segment_slope;
		logic signed [DATA_W-1:0] segment_offset;
		logic signed [DATA_W-1:0] expected_value;
		logic [KIND_W-1:0]        expected_kind;
	} directed_row_t;

	// Ways in which the result side holds off the block.
	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	pae_in_if  req ();
	pae_out_if rsp ();

	piecewise_affine_evaluator_top #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Our own copy of the breakpoint table and of the count register. Both
	// follow the block as requests and register writes are accepted.
	logic signed [DATA_W-1:0] knot_pos   [MAX_POINTS];
	logic signed [DATA_W-1:0] knot_val   [MAX_POINTS];
	logic signed [DATA_W-1:0] seg_slope  [MAX_POINTS];
	logic signed [DATA_W-1:0] seg_offset [MAX_POINTS];
	int                       count_setting;

	// Results still owed by the block, oldest first.
	evaluation_t pending_results [$];

	int       mismatch_count = 0;
	int       quiet_cycles   = 0;
	rx_mode_t stall_mode     = RX_COIN;
	int       stall_left     = 0;
	int       rx_tick        = 0;
	int       max_gap        = 0;
	int       burst_left     = 0;

	directed_row_t directed_rows [$];

	// The function value at a query position. The first valid breakpoint at
	// or above the position is selected in index order, exactly as a priority
	// encoder would, so an unsorted table is handled the same way.
	function automatic evaluation_t evaluate_at(logic signed [DATA_W-1:0] q);
		evaluation_t e;
		int          n;
		int          sel;
		bit          found;
		longint      acc;
		e.value     = '0;
		e.kind      = HIT_OUTSIDE;
		e.saturated = 1'b0;
		found       = 1'b0;
		sel         = 0;
		n           = (count_setting > MAX_POINTS) ? MAX_POINTS : count_setting;
		for (int i = 0; i < n; i++) begin
			if (!found && knot_pos[i] >= q) begin
				sel   = i;
				found = 1'b1;
			end
		end
		if (found) begin
			if (knot_pos[sel] == q) begin
				e.value = knot_val[sel];
				e.kind  = HIT_EXACT;
			end else if (sel != 0) begin
				// The product is 64 bits wide; an arithmetic shift rounds it
				// towards minus infinity before the offset is added.
				acc = (longint'(seg_slope[sel-1]) * longint'(q)) >>> FRAC_BITS;
				acc = acc + longint'(seg_offset[sel-1]);
				if (acc > WORD_MAX) begin
					acc         = WORD_MAX;
					e.saturated = 1'b1;
				end else if (acc < WORD_MIN) begin
					acc         = WORD_MIN;
					e.saturated = 1'b1;
				end
				e.value = acc[DATA_W-1:0];
				e.kind  = HIT_SEGMENT;
			end
		end
		return e;
	endfunction

	function automatic directed_row_t make_row(row_kind_t kind, int arg,
			logic signed [DATA_W-1:0] position, logic signed [DATA_W-1:0] point_value,
			logic signed [DATA_W-1:0] segment_slope,
			logic signed [DATA_W-1:0] segment_offset,
			logic signed [DATA_W-1:0] expected_value, logic [KIND_W-1:0] expected_kind);
		directed_row_t row;
		row.kind           = kind;
		row.arg            = arg;
		row.position       = position;
		row.point_value    = point_value;
		row.segment_slope  = segment_slope;
		row.segment_offset = segment_offset;
		row.expected_value = expected_value;
		row.expected_kind  = expected_kind;
		return row;
	endfunction

	function automatic void append_row(directed_row_t row);
		directed_rows = {directed_rows, row};
	endfunction

	// Data words: mostly anything, often small, now and then an extreme.
	function automatic logic signed [DATA_W-1:0] random_word();
		int pick;
		pick = $urandom_range(0, 11);
		case (pick)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return -32'sd1;
			4, 5, 6: return $signed($urandom) >>> $urandom_range(8, 28);
			default: return $signed($urandom);
		endcase
	endfunction

	// Query positions aimed at the table as it stands: on a breakpoint,
	// strictly between two neighbours, just outside either end, or anywhere.
	function automatic logic signed [DATA_W-1:0] pick_query();
		int                  n;
		int                  i;
		int                  pick;
		longint              lo;
		longint              hi;
		longint              span;
		longint              q64;
		longint unsigned     draw;
		n    = (count_setting > MAX_POINTS) ? MAX_POINTS : count_setting;
		pick = $urandom_range(0, 19);
		if (n == 0)
			return random_word();
		if (pick <= 7)
			return knot_pos[$urandom_range(0, n - 1)];
		if (pick <= 13 && n >= 2) begin
			i  = $urandom_range(0, n - 2);
			lo = knot_pos[i];
			hi = knot_pos[i+1];
			if (lo > hi) begin
				span = lo;
				lo   = hi;
				hi   = span;
			end
			span = hi - lo - 1;
			if (span <= 0)
				return lo[DATA_W-1:0];
			draw = {$urandom, $urandom};
			q64  = lo + 1 + longint'(draw % span);
			return q64[DATA_W-1:0];
		end
		if (pick == 14)
			return knot_pos[0] - 1;
		if (pick == 15)
			return knot_pos[n-1] + 1;
		if (pick == 16)
			return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		return random_word();
	endfunction

	// Drive one request at the falling edge and hold it until the block takes
	// it. The table copy and the queue of owed results are updated at the very
	// edge where the request is accepted.
	task automatic send_request(input request_t r, input bit typed,
			input evaluation_t typed_result);
		@(negedge clk);
		req.cmd            = r.cmd;
		req.entry_index    = r.entry_index;
		req.position       = r.position;
		req.point_value    = r.point_value;
		req.segment_slope  = r.segment_slope;
		req.segment_offset = r.segment_offset;
		req.valid          = 1'b1;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		if (r.cmd == CMD_LOAD) begin
			knot_pos[r.entry_index]   = r.position;
			knot_val[r.entry_index]   = r.point_value;
			seg_slope[r.entry_index]  = r.segment_slope;
			seg_offset[r.entry_index] = r.segment_offset;
		end else begin
			pending_results = {pending_results,
				(typed ? typed_result : evaluate_at(r.position))};
		end
	endtask

	// The sender works in bursts; between bursts valid stays low for a while.
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
			repeat (gap) begin
				@(negedge clk);
				req.valid = 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	// Stop sending and wait until every owed result is back. A load gives no
	// result, so a settling pause follows before the block is taken as idle.
	task automatic wait_for_results(input int extra);
		@(negedge clk);
		req.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (extra)
			@(negedge clk);
	endtask

	task automatic write_point_count(input int value);
		@(negedge clk);
		cfg_wdata = value[COUNT_W-1:0];
		cfg_we    = 1'b1;
		@(posedge clk);
		count_setting = value[COUNT_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Write all sixteen entries in a shuffled order. Most tables are sorted;
	// the rest keep their raw order and exercise the priority selection. The
	// spread of the positions changes from table to table, so that dense
	// tables with repeated positions show up as well as sparse ones.
	task automatic reload_table();
		logic signed [DATA_W-1:0] fresh [MAX_POINTS];
		logic signed [DATA_W-1:0] held;
		int                       order [MAX_POINTS];
		int                       scale;
		int                       j;
		int                       k;
		request_t                 r;
		scale = $urandom_range(0, 26);
		for (int i = 0; i < MAX_POINTS; i++)
			fresh[i] = $signed($urandom) >>> scale;
		if ($urandom_range(0, 6) != 0) begin
			for (int i = 1; i < MAX_POINTS; i++) begin
				held = fresh[i];
				k    = i - 1;
				while (k >= 0 && fresh[k] > held) begin
					fresh[k+1] = fresh[k];
					k--;
				end
				fresh[k+1] = held;
			end
		end
		for (int i = 0; i < MAX_POINTS; i++)
			order[i] = i;
		for (int i = MAX_POINTS - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			k        = order[i];
			order[i] = order[j];
			order[j] = k;
		end
		for (int i = 0; i < MAX_POINTS; i++) begin
			r.cmd            = CMD_LOAD;
			r.entry_index    = order[i][INDEX_W-1:0];
			r.position       = fresh[order[i]];
			r.point_value    = random_word();
			r.segment_slope  = random_word();
			r.segment_offset = random_word();
			pace();
			send_request(r, 1'b0, '0);
		end
	endtask

	// A quarter of the random requests are loads. Most loads keep the
	// position of the entry and only change its data, so a sorted table stays
	// sorted; the others move the breakpoint anywhere.
	task automatic make_random_request(output request_t r);
		r.entry_index    = INDEX_W'($urandom_range(0, MAX_POINTS - 1));
		r.point_value    = random_word();
		r.segment_slope  = random_word();
		r.segment_offset = random_word();
		if ($urandom_range(0, 3) == 0) begin
			r.cmd      = CMD_LOAD;
			r.position = ($urandom_range(0, 9) < 7) ? knot_pos[r.entry_index] :
				random_word();
		end else begin
			r.cmd      = CMD_EVAL;
			r.position = pick_query();
		end
	endtask

	task automatic note_mismatch(input string what, input logic [DATA_W-1:0] expected_v,
			input logic [DATA_W-1:0] actual_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what,
				expected_v, actual_v);
	endtask

	// The result side holds off the block in one of four ways: never, by a
	// coin toss each cycle, by a fixed duty pattern, or in long rare stalls.
	always @(negedge clk) begin
		case (stall_mode)
			RX_ALWAYS: rsp.ready = 1'b1;
			RX_COIN: rsp.ready = ($urandom_range(0, 1) != 0);
			RX_PERIODIC: begin
				rsp.ready = ((rx_tick % 7) < 4);
				rx_tick++;
			end
			default: begin
				if (stall_left > 0) begin
					rsp.ready = 1'b0;
					stall_left--;
				end else if ($urandom_range(0, 15) == 0) begin
					rsp.ready  = 1'b0;
					stall_left = $urandom_range(4, 15);
				end else begin
					rsp.ready = 1'b1;
				end
			end
		endcase
	end

	// Every accepted result is checked against the oldest owed one.
	always @(posedge clk) begin
		evaluation_t owed;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unrequested result", '0, rsp.result_value);
			end else begin
				owed = pending_results.pop_front();
				if (rsp.result_value !== owed.value)
					note_mismatch("result_value", owed.value, rsp.result_value);
				if (rsp.hit_kind !== owed.kind)
					note_mismatch("hit_kind", DATA_W'(owed.kind), DATA_W'(rsp.hit_kind));
				if (rsp.saturated !== owed.saturated)
					note_mismatch("saturated", DATA_W'(owed.saturated),
						DATA_W'(rsp.saturated));
			end
		end
	end

	// A run that stops moving is ended: no request, no result and no register
	// write for far longer than any correct run would need.
	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		directed_row_t row;
		request_t      r;
		evaluation_t   typed;
		int            count_plan [PHASES];
		int            gap_plan   [PHASES];

		req.valid          = 1'b0;
		req.cmd            = CMD_LOAD;
		req.entry_index    = '0;
		req.position       = '0;
		req.point_value    = '0;
		req.segment_slope  = '0;
		req.segment_offset = '0;
		rsp.ready          = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		arst_n             = 1'b0;

		// After reset only entry 0 is known (position and value zero) and the
		// count is one.
		count_setting = 1;
		for (int i = 0; i < MAX_POINTS; i++) begin
			knot_pos[i]   = '0;
			knot_val[i]   = '0;
			seg_slope[i]  = '0;
			seg_offset[i] = '0;
		end

		// Directed part. The first three queries run on the reset table: on
		// the single breakpoint, before it, and past it. Then a four-entry
		// table is built with an ordinary segment, a segment steep enough to
		// clip upwards, one that clips downwards, and a last breakpoint at the
		// top of the range. Queries hit each breakpoint, both ends of the
		// range, a position just under a breakpoint, an empty table, and a
		// count beyond the table size.
		append_row(make_row(ROW_EXPECT, 0, 32'sh0000_0000, 0, 0, 0,
			32'sh0000_0000, HIT_EXACT));
		append_row(make_row(ROW_EXPECT, 0, -32'sd1, 0, 0, 0,
			32'sh0000_0000, HIT_OUTSIDE));
		append_row(make_row(ROW_EXPECT, 0, 32'sh0000_0001, 0, 0, 0,
			32'sh0000_0000, HIT_OUTSIDE));
		append_row(make_row(ROW_LOAD, 0, 32'shFFF6_0000, 32'sh0005_0000,
			32'sh0001_0000, 32'sh0000_0000, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_LOAD, 1, 32'sh0000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_LOAD, 2, 32'sh0010_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_LOAD, 3, 32'sh7FFF_FFFF, -32'sd1,
			32'sh0000_0000, 32'sh0000_0000, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_COUNT, 4, 0, 0, 0, 0, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_EXPECT, 0, 32'shFFF6_0000, 0, 0, 0,
			32'sh0005_0000, HIT_EXACT));
		append_row(make_row(ROW_EXPECT, 0, 32'sh8000_0000, 0, 0, 0,
			32'sh0000_0000, HIT_OUTSIDE));
		append_row(make_row(ROW_QUERY, 0, 32'shFFFB_0000, 0, 0, 0, 0,
			HIT_OUTSIDE));
		append_row(make_row(ROW_QUERY, 0, -32'sd1, 0, 0, 0, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_QUERY, 0, 32'sh0000_0001, 0, 0, 0, 0,
			HIT_OUTSIDE));
		append_row(make_row(ROW_EXPECT, 0, 32'sh0000_0000, 0, 0, 0,
			32'sh7FFF_FFFF, HIT_EXACT));
		append_row(make_row(ROW_EXPECT, 0, 32'sh0010_0000, 0, 0, 0,
			32'sh8000_0000, HIT_EXACT));
		append_row(make_row(ROW_QUERY, 0, 32'sh0010_0001, 0, 0, 0, 0,
			HIT_OUTSIDE));
		append_row(make_row(ROW_EXPECT, 0, 32'sh7FFF_FFFF, 0, 0, 0,
			-32'sd1, HIT_EXACT));
		append_row(make_row(ROW_COUNT, 0, 0, 0, 0, 0, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_EXPECT, 0, 32'sh0000_0000, 0, 0, 0,
			32'sh0000_0000, HIT_OUTSIDE));
		// With the count at its top value the scan still stops inside the
		// four written entries, as every query here lies at or below the last.
		append_row(make_row(ROW_COUNT, 31, 0, 0, 0, 0, 0, HIT_OUTSIDE));
		append_row(make_row(ROW_QUERY, 0, 32'sh0008_0000, 0, 0, 0, 0,
			HIT_OUTSIDE));
		append_row(make_row(ROW_EXPECT, 0, 32'sh7FFF_FFFF, 0, 0, 0,
			-32'sd1, HIT_EXACT));

		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			if (row.kind == ROW_COUNT) begin
				wait_for_results(SETTLE_CYCLES);
				write_point_count(row.arg);
			end else begin
				r.cmd             = (row.kind == ROW_LOAD) ? CMD_LOAD : CMD_EVAL;
				r.entry_index     = row.arg[INDEX_W-1:0];
				r.position        = row.position;
				r.point_value     = row.point_value;
				r.segment_slope   = row.segment_slope;
				r.segment_offset  = row.segment_offset;
				typed.value       = row.expected_value;
				typed.kind        = row.expected_kind;
				typed.saturated   = 1'b0;
				send_request(r, row.kind == ROW_EXPECT, typed);
			end
		end

		// Random part. Each phase waits for the block to go idle, sets a new
		// count, rewrites the whole table so that no query can reach an
		// entry that was never written, and then mixes loads and queries.
		// The phases go through the extremes of the count, an empty table and
		// counts beyond the table, under different sender and receiver
		// habits; the first phase runs with no idling on either side.
		count_plan    = '{16, 31, 0, 1, 2, 17, 0, 0};
		count_plan[6] = $urandom_range(3, 15);
		count_plan[7] = $urandom_range(0, 31);
		gap_plan      = '{0, 24, 12, 3, 6, 0, 30, 2};
		for (int p = 0; p < PHASES; p++) begin
			wait_for_results(SETTLE_CYCLES);
			stall_mode = rx_mode_t'(p % 4);
			max_gap    = gap_plan[p];
			burst_left = 0;
			write_point_count(count_plan[p]);
			reload_table();
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Now and then the sender holds back until the block has
				// handed over everything it owes.
				if ($urandom_range(0, 199) == 0)
					wait_for_results(0);
				make_random_request(r);
				pace();
				send_request(r, 1'b0, '0);
			end
		end

		wait_for_results(SETTLE_CYCLES);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
